/* rtl/uart_pkg.sv */
// Shared constants, types and register codes of the UART transceiver.
package uart_pkg;

    localparam int TICK_COUNTER_WIDTH = 16;
    localparam int MAX_CHAR_BITS      = 8;

    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int TX_CNT_W     = TICK_COUNTER_WIDTH;
    localparam int RX_CNT_W     = TICK_COUNTER_WIDTH + 1;
    localparam int CMP_W        = (TX_CNT_W > CFG_DATA_W) ? TX_CNT_W : CFG_DATA_W;
    localparam int TX_SHIFT_W   = MAX_CHAR_BITS + 4;
    localparam int RX_SHIFT_W   = MAX_CHAR_BITS + 1;
    localparam int BITS_W       = 4;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    localparam logic [BITS_W-1:0] CHAR_BITS_MIN = BITS_W'(5);
    localparam logic [BITS_W-1:0] CHAR_BITS_MAX = BITS_W'(MAX_CHAR_BITS);
    localparam logic [BITS_W-1:0] FRAME_MAX     = BITS_W'(MAX_CHAR_BITS + 4);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BIT_PERIOD  = 2'd0,
        REG_CHAR_BITS   = 2'd1,
        REG_PARITY_MODE = 2'd2,
        REG_STOP_COUNT  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PAR_OFF  = 2'd0,
        PAR_ODD  = 2'd1,
        PAR_EVEN = 2'd2
    } parity_mode_t;

    typedef struct packed {
        logic                     tx_line;
        logic                     tx_busy;
        logic                     rx_valid;
        logic [7:0]               rx_byte;
        logic                     rx_parity_error;
    } result_t;

endpackage

/* rtl/uart_transceiver.sv */
// UART transceiver top level: one tick per transaction, framing, sampling and parity.
//
//  channel   | ports                         | payload, lowest bit up
//  ----------+-------------------------------+------------------------------------------
//  s_ (in)   | s_tvalid s_tready s_tdata[15:0]| rx_line, tx_start, tx_byte[7:0], zero pad
//  m_ (out)  | m_tvalid m_tready m_tdata[15:0]| tx_line, tx_busy, rx_valid, rx_byte[7:0],
//            |                               | rx_parity_error, zero pad
//  cfg (wr)  | cfg_wr_en cfg_index cfg_wr_data| bit period, character length, parity mode,
//            |                               | stop count
//
// One transaction per cycle sustained while m_ accepts; a tick passes an input register and one
// stage of counter and shift logic into the result register.
// Transmit and receive counters advance only when a tick moves into the result register.
// A stall on m_ holds the result register; s_tready then drops once the input register fills.
// aresetn is synchronous, active low, and restores the configuration defaults.
module uart_transceiver
    import uart_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // rx_line, tx_start, tx_byte[7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // tx_line, tx_busy, rx_valid, rx_byte, rx_parity_error
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    logic [CFG_DATA_W-1:0] bit_period_reg;
    logic [BITS_W-1:0]     char_bits_reg;
    logic [1:0]            parity_mode_reg;
    logic [1:0]            stop_count_reg;

    logic       in_valid_reg;
    logic       in_rx_line_reg;
    logic       in_tx_start_reg;
    logic [7:0] in_tx_byte_reg;

    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic [TX_SHIFT_W-1:0] tx_shift_reg, tx_shift_next;
    logic [BITS_W-1:0]     tx_bits_left_reg, tx_bits_left_next;
    logic [TX_CNT_W-1:0]   tx_tick_count_reg, tx_tick_count_next;
    logic                  rx_prev_level_reg;
    logic                  rx_active_reg, rx_active_next;
    logic [RX_CNT_W-1:0]   rx_tick_count_reg, rx_tick_count_next;
    logic [RX_SHIFT_W-1:0] rx_shift_reg, rx_shift_next;
    logic [BITS_W-1:0]     rx_bits_left_reg, rx_bits_left_next;

    logic out_ready;
    logic advance;

    logic [BITS_W-1:0]        eff_data;
    logic                     eff_parity;
    logic [1:0]               eff_stop;
    logic [CFG_DATA_W-1:0]    period;
    logic [TX_CNT_W-1:0]      tx_cnt_inc;
    logic [MAX_CHAR_BITS-1:0] tx_data;
    logic                     tx_odd;
    logic [BITS_W-1:0]        rx_total;
    logic [MAX_CHAR_BITS-1:0] rx_data;
    logic                     rx_par_bit;
    logic                     rx_cnt_odd;
    logic                     perr;
    logic [CFG_DATA_W:0]      rx_start_offset;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_reg.rx_parity_error, out_reg.rx_byte, out_reg.rx_valid,
                        out_reg.tx_busy, out_reg.tx_line};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg  <= CFG_DATA_W'(104);
            char_bits_reg   <= BITS_W'(8);
            parity_mode_reg <= PAR_OFF;
            stop_count_reg  <= 2'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_BIT_PERIOD:  bit_period_reg  <= cfg_wr_data;
                REG_CHAR_BITS:   char_bits_reg   <= cfg_wr_data[BITS_W-1:0];
                REG_PARITY_MODE: parity_mode_reg <= cfg_wr_data[1:0];
                REG_STOP_COUNT:  stop_count_reg  <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_rx_line_reg  <= s_tdata[0];
            in_tx_start_reg <= s_tdata[1];
            in_tx_byte_reg  <= s_tdata[9:2];
        end
    end

    always_comb begin
        eff_data = char_bits_reg;
        if (char_bits_reg < CHAR_BITS_MIN) begin
            eff_data = CHAR_BITS_MIN;
        end else if (char_bits_reg > CHAR_BITS_MAX) begin
            eff_data = CHAR_BITS_MAX;
        end
        eff_parity = (parity_mode_reg == PAR_ODD) || (parity_mode_reg == PAR_EVEN);
        eff_stop   = (stop_count_reg >= 2'd2) ? 2'd2 : 2'd1;
        period     = (bit_period_reg == '0) ? CFG_DATA_W'(1) : bit_period_reg;
        tx_cnt_inc = tx_tick_count_reg + TX_CNT_W'(1);

        tx_data = MAX_CHAR_BITS'(in_tx_byte_reg);
        for (int i = 0; i < MAX_CHAR_BITS; i++) begin
            if (BITS_W'(i) >= eff_data) begin
                tx_data[i] = 1'b0;
            end
        end
        tx_odd = ^tx_data;

        // transmit
        tx_shift_next      = tx_shift_reg;
        tx_bits_left_next  = tx_bits_left_reg;
        tx_tick_count_next = tx_tick_count_reg;
        if (tx_bits_left_reg != '0) begin
            tx_tick_count_next = tx_cnt_inc;
            if (CMP_W'(tx_cnt_inc) >= CMP_W'(period)) begin
                tx_tick_count_next = '0;
                tx_shift_next      = {1'b1, tx_shift_reg[TX_SHIFT_W-1:1]};
                tx_bits_left_next  = tx_bits_left_reg - BITS_W'(1);
            end
        end else if (in_tx_start_reg) begin
            tx_shift_next = '1;
            tx_shift_next[0] = 1'b0;
            for (int i = 0; i < MAX_CHAR_BITS; i++) begin
                if (BITS_W'(i) < eff_data) begin
                    tx_shift_next[i+1] = tx_data[i];
                end
            end
            for (int i = 0; i < MAX_CHAR_BITS + 1; i++) begin
                if (eff_parity && BITS_W'(i) == eff_data) begin
                    tx_shift_next[i+1] = (parity_mode_reg == PAR_ODD) ? !tx_odd : tx_odd;
                end
            end
            tx_bits_left_next  = BITS_W'(1) + eff_data + BITS_W'(eff_parity)
                                 + BITS_W'(eff_stop);
            tx_tick_count_next = '0;
        end

        // receive
        rx_total           = eff_data + BITS_W'(eff_parity);
        rx_start_offset    = {1'b0, bit_period_reg}
                             + (CFG_DATA_W + 1)'(bit_period_reg[CFG_DATA_W-1:1]);
        rx_active_next     = rx_active_reg;
        rx_tick_count_next = rx_tick_count_reg;
        rx_shift_next      = rx_shift_reg;
        rx_bits_left_next  = rx_bits_left_reg;
        rx_data            = '0;
        rx_par_bit         = 1'b0;
        rx_cnt_odd         = 1'b0;
        perr               = 1'b0;
        out_next.rx_valid  = 1'b0;
        out_next.rx_byte   = '0;
        if (rx_active_reg) begin
            if (rx_tick_count_reg <= RX_CNT_W'(1)) begin
                rx_tick_count_next = RX_CNT_W'(bit_period_reg);
                rx_shift_next = rx_shift_reg >> 1;
                for (int i = 0; i < RX_SHIFT_W; i++) begin
                    if (BITS_W'(i + 1) == rx_total) begin
                        rx_shift_next[i] = rx_shift_next[i] | in_rx_line_reg;
                    end
                end
                if (rx_bits_left_reg != '0) begin
                    rx_bits_left_next = rx_bits_left_reg - BITS_W'(1);
                end
                for (int i = 0; i < MAX_CHAR_BITS; i++) begin
                    if (BITS_W'(i) < eff_data) begin
                        rx_data[i] = rx_shift_next[i];
                    end
                end
                for (int i = 0; i < RX_SHIFT_W; i++) begin
                    if (BITS_W'(i) == eff_data) begin
                        rx_par_bit = rx_shift_next[i];
                    end
                end
                rx_cnt_odd = (^rx_data) ^ rx_par_bit;
                if (rx_bits_left_next == '0) begin
                    rx_active_next    = 1'b0;
                    out_next.rx_valid = 1'b1;
                    if (eff_parity) begin
                        perr = ((parity_mode_reg == PAR_ODD) && !rx_cnt_odd) ||
                               ((parity_mode_reg == PAR_EVEN) && rx_cnt_odd);
                    end
                    out_next.rx_byte = perr ? 8'd0 : 8'(rx_data);
                end
            end else begin
                rx_tick_count_next = rx_tick_count_reg - RX_CNT_W'(1);
            end
        end else if (rx_prev_level_reg && !in_rx_line_reg) begin
            rx_active_next     = 1'b1;
            rx_tick_count_next = RX_CNT_W'(rx_start_offset);
            rx_shift_next      = '0;
            rx_bits_left_next  = rx_total;
        end

        out_next.rx_parity_error = perr;
        out_next.tx_busy         = (tx_bits_left_next != '0);
        out_next.tx_line         = (tx_bits_left_next != '0) ? tx_shift_next[0] : 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_shift_reg      <= '1;
            tx_bits_left_reg  <= '0;
            tx_tick_count_reg <= '0;
            rx_prev_level_reg <= 1'b1;
            rx_active_reg     <= 1'b0;
            rx_tick_count_reg <= '0;
            rx_shift_reg      <= '0;
            rx_bits_left_reg  <= '0;
        end else if (advance) begin
            tx_shift_reg      <= tx_shift_next;
            tx_bits_left_reg  <= tx_bits_left_next;
            tx_tick_count_reg <= tx_tick_count_next;
            rx_prev_level_reg <= in_rx_line_reg;
            rx_active_reg     <= rx_active_next;
            rx_tick_count_reg <= rx_tick_count_next;
            rx_shift_reg      <= rx_shift_next;
            rx_bits_left_reg  <= rx_bits_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_perr_with_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.rx_parity_error |-> out_reg.rx_valid)
        else $error("parity error flagged without a received character");

    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.tx_busy |-> out_reg.tx_line)
        else $error("transmit line low while idle");

    a_byte_zero_unless_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.rx_valid |-> out_reg.rx_byte == 8'd0)
        else $error("received byte set without rx_valid");

    a_tx_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_bits_left_reg <= FRAME_MAX)
        else $error("transmit bit count beyond frame length");

    a_rx_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_bits_left_reg <= BITS_W'(RX_SHIFT_W))
        else $error("receive bit count beyond character length");

    a_state_holds_without_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(tx_bits_left_reg) && $stable(rx_active_reg))
        else $error("tick state moved without a transaction");

endmodule
